// ----- rtl/bgd_pkg.sv -----
// shared types and constants of the button gesture detector
// no dependencies; imported by every other file of the block
package bgd_pkg;

  localparam int CNT_W = 32;
  localparam int TMR_W = 16;
  localparam int BTN_W = 2;
  localparam int IDX_W = 3;
  localparam int CC_W  = 8;
  localparam int LEV_W = 4;

  localparam logic [IDX_W-1:0] REG_LONG_PRESS  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MULTI_PRESS = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_REPEAT_EN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_REPEAT_IVL  = 3'd4;
  localparam logic [IDX_W-1:0] REG_DETECT_EN   = 3'd5;

  localparam logic [TMR_W-1:0] LONG_PRESS_RST  = 16'd2000;
  localparam logic [TMR_W-1:0] MULTI_PRESS_RST = 16'd500;
  localparam logic [TMR_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [TMR_W-1:0] REPEAT_IVL_RST  = 16'd200;

  localparam logic [CC_W-1:0] CC_MAX = 8'd255;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_LONG    = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_TRIPLE  = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOLD,
    ST_REPEAT,
    ST_WINDOW,
    ST_CHANGE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [BTN_W-1:0] btn;
    event_t           code;
    logic [CNT_W-1:0] total;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] now;
    logic [CNT_W-1:0] stamp;
    logic [TMR_W-1:0] debounce;
    logic [TMR_W-1:0] multi;
    logic [TMR_W-1:0] countdown;
  } unit_req_t;

  typedef struct packed {
    logic             lt_debounce;
    logic             le_multi;
    logic             expire;
    logic [TMR_W-1:0] countdown_next;
  } unit_rsp_t;

  typedef struct packed {
    logic room;
    logic pend_valid;
  } out_status_t;

endpackage

// ----- rtl/bgd_unit.sv -----
// shared arithmetic unit: elapsed time compares and countdown step
// depends on bgd_pkg
module bgd_unit (
  input  bgd_pkg::unit_req_t req,
  output bgd_pkg::unit_rsp_t rsp
);
  import bgd_pkg::*;

  logic [CNT_W-1:0] elapsed;

  assign elapsed = req.now - req.stamp;

  always_comb begin
    rsp.lt_debounce    = elapsed < {{(CNT_W-TMR_W){1'b0}}, req.debounce};
    rsp.le_multi       = elapsed <= {{(CNT_W-TMR_W){1'b0}}, req.multi};
    rsp.expire         = req.countdown <= TMR_W'(1);
    rsp.countdown_next = rsp.expire ? '0 : req.countdown - TMR_W'(1);
  end

endmodule

// ----- rtl/bgd_out.sv -----
// result stage: holds one result back so the final one can carry tlast
// depends on bgd_pkg
module bgd_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  flush,
  input  bgd_pkg::result_t      res,
  output bgd_pkg::out_status_t  status,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,  // button_index[1:0], press_total[33:2], zeros
  output logic [2:0]            m_tuser,  // event_code
  output logic                  m_tlast
);
  import bgd_pkg::*;

  result_t pend;
  result_t out_res;
  logic    pend_valid;
  logic    out_valid;
  logic    out_last;
  logic    out_free;
  logic    load_push;
  logic    load_flush;

  assign out_free   = !out_valid || m_tready;
  assign load_push  = push && (!pend_valid || out_free);
  assign load_flush = !push && flush && pend_valid && out_free;

  assign status.room       = !pend_valid || out_free;
  assign status.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (load_push) begin
      pend_valid <= 1'b1;
      if (pend_valid) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end else if (load_flush) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_push) begin
      pend <= res;
      if (pend_valid) begin
        out_res  <= pend;
        out_last <= 1'b0;
      end
    end else if (load_flush) begin
      out_res  <= pend;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_res.total, out_res.btn};
  assign m_tuser  = out_res.code;
  assign m_tlast  = out_last;

endmodule

// ----- rtl/button_gesture_detector.sv -----
// button gesture detector top level: sequencer, per-button state, config
// depends on bgd_pkg, bgd_unit, bgd_out
//
// usage:
//   s_* channel takes one request at a time: s_tuser is the opcode (0 tick,
//   1 level change), s_tdata carries levels and the changed mask.
//   m_* channel returns zero to eight events per request, tlast on the final.
//   wr_en/wr_index/wr_data write the six config registers; the user must
//   write only while idle, as the block itself does not enforce it.
// timing:
//   a tick walks the buttons one at a time through the shared unit: a hold
//   step and a window step per button, with a repeat step between them when
//   its hold timer expires, then a closing step for the request; a level
//   change takes a change step per button and the closing step, and a change
//   while disabled only the closing step. s_tready is high only between requests.
// reset clears all config to defaults and all button state, no sweep needed.
// a stalled receiver holds the sequencer when an event is due or the request
// closes while both the held-back result and the output register are full;
// the last result may wait in the output register while the next request is taken.
module button_gesture_detector #(
  parameter int BUTTONS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // levels[3:0], changed_mask[7:4]
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // button_index[1:0], press_total[33:2], zeros
  output logic [2:0]  m_tuser,   // event_code
  output logic        m_tlast,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data
);
  import bgd_pkg::*;

  localparam int ACTIVE = (BUTTONS < 4) ? BUTTONS : 4;
  localparam int IW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam logic [IW-1:0] LAST_BTN = IW'(ACTIVE - 1);

  // config
  logic [TMR_W-1:0] long_press_ms;
  logic [TMR_W-1:0] multi_press_ms;
  logic [TMR_W-1:0] debounce_ms;
  logic             repeat_enable;
  logic [TMR_W-1:0] repeat_ivl;
  logic             detector_enable;
  logic             disable_write;

  // per-button state
  logic [ACTIVE-1:0] held_flag;
  logic [ACTIVE-1:0] prior_level;
  logic [ACTIVE-1:0] long_fired;
  logic [ACTIVE-1:0] debounce_armed;
  logic [ACTIVE-1:0] hold_armed;
  logic [ACTIVE-1:0] window_armed;
  logic [CNT_W-1:0]  release_stamp [ACTIVE];
  logic [CNT_W-1:0]  press_tally [ACTIVE];
  logic [CC_W-1:0]   consec [ACTIVE];
  logic [TMR_W-1:0]  hold_cd [ACTIVE];
  logic [TMR_W-1:0]  window_cd [ACTIVE];

  logic [CNT_W-1:0] now_count;
  logic [LEV_W-1:0] item_levels;
  logic [LEV_W-1:0] item_mask;
  logic [IW-1:0]    btn;

  state_t state;
  state_t state_next;

  unit_req_t   ureq;
  unit_rsp_t   ursp;
  out_status_t ost;
  result_t     res;

  logic   accept;
  logic   step;
  logic   go;
  logic   emit;
  event_t emit_code;
  logic   hold_exp;
  logic   win_exp;
  logic   chg;
  logic   pressed;
  logic   bounce;
  logic   do_press;
  logic   do_release;

  assign s_tready      = (state == ST_IDLE);
  assign accept        = s_tvalid && s_tready;
  assign disable_write = wr_en && (wr_index == REG_DETECT_EN) && !wr_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms   <= LONG_PRESS_RST;
      multi_press_ms  <= MULTI_PRESS_RST;
      debounce_ms     <= DEBOUNCE_RST;
      repeat_enable   <= 1'b0;
      repeat_ivl      <= REPEAT_IVL_RST;
      detector_enable <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        REG_LONG_PRESS:  long_press_ms   <= wr_data;
        REG_MULTI_PRESS: multi_press_ms  <= wr_data;
        REG_DEBOUNCE:    debounce_ms     <= wr_data;
        REG_REPEAT_EN:   repeat_enable   <= wr_data[0];
        REG_REPEAT_IVL:  repeat_ivl      <= wr_data;
        REG_DETECT_EN:   detector_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

  // shared unit operands follow the current button and phase
  always_comb begin
    ureq.now       = now_count;
    ureq.stamp     = release_stamp[btn];
    ureq.debounce  = debounce_ms;
    ureq.multi     = multi_press_ms;
    ureq.countdown = (state == ST_WINDOW) ? window_cd[btn] : hold_cd[btn];
  end

  bgd_unit u_unit (
    .req (ureq),
    .rsp (ursp)
  );

  always_comb begin
    hold_exp   = hold_armed[btn] && ursp.expire;
    win_exp    = window_armed[btn] && ursp.expire;
    chg        = item_mask[btn];
    pressed    = item_levels[btn];
    bounce     = debounce_armed[btn] && ursp.lt_debounce;
    do_press   = chg && !bounce && pressed && !prior_level[btn];
    do_release = chg && !bounce && !pressed && prior_level[btn];
  end

  // outputs of the sequencer
  always_comb begin
    emit      = 1'b0;
    emit_code = EV_PRESS;
    step      = 1'b0;
    case (state)
      ST_HOLD: begin
        step      = 1'b1;
        emit      = hold_exp && held_flag[btn] && !long_fired[btn];
        emit_code = EV_LONG;
      end
      ST_REPEAT: begin
        step      = 1'b1;
        emit      = repeat_enable && held_flag[btn] && long_fired[btn];
        emit_code = EV_PRESS;
      end
      ST_WINDOW: begin
        step = 1'b1;
        emit = win_exp && (consec[btn] != '0);
        if (consec[btn] == CC_W'(1)) begin
          emit_code = EV_PRESS;
        end else if (consec[btn] == CC_W'(2)) begin
          emit_code = EV_DOUBLE;
        end else begin
          emit_code = EV_TRIPLE;
        end
      end
      ST_CHANGE: begin
        step      = 1'b1;
        emit      = do_release;
        emit_code = EV_RELEASE;
      end
      default: ;
    endcase
  end

  assign go = step && (!emit || ost.room);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!s_tuser) begin
            state_next = ST_HOLD;
          end else if (detector_enable) begin
            state_next = ST_CHANGE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_HOLD: begin
        if (go) begin
          state_next = hold_exp ? ST_REPEAT : ST_WINDOW;
        end
      end
      ST_REPEAT: begin
        if (go) begin
          state_next = ST_WINDOW;
        end
      end
      ST_WINDOW: begin
        if (go) begin
          state_next = (btn == LAST_BTN) ? ST_DONE : ST_HOLD;
        end
      end
      ST_CHANGE: begin
        if (go && btn == LAST_BTN) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ost.room) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now_count <= '0;
      btn       <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        btn <= '0;
        if (!s_tuser) begin
          now_count <= now_count + CNT_W'(1);
        end
      end else if (go && (state == ST_WINDOW || state == ST_CHANGE) && btn != LAST_BTN) begin
        btn <= btn + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_levels <= s_tdata[3:0];
      item_mask   <= s_tdata[7:4];
    end
  end

  // per-button state update
  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag      <= '0;
      prior_level    <= '0;
      long_fired     <= '0;
      debounce_armed <= '0;
      hold_armed     <= '0;
      window_armed   <= '0;
      for (int i = 0; i < ACTIVE; i++) begin
        release_stamp[i] <= '0;
        press_tally[i]   <= '0;
        consec[i]        <= '0;
        hold_cd[i]       <= '0;
        window_cd[i]     <= '0;
      end
    end else if (disable_write) begin
      held_flag      <= '0;
      prior_level    <= '0;
      long_fired     <= '0;
      debounce_armed <= '0;
      hold_armed     <= '0;
      window_armed   <= '0;
      for (int i = 0; i < ACTIVE; i++) begin
        consec[i]    <= '0;
        hold_cd[i]   <= '0;
        window_cd[i] <= '0;
      end
    end else if (go) begin
      case (state)
        ST_HOLD: begin
          if (hold_armed[btn]) begin
            hold_cd[btn] <= ursp.countdown_next;
            if (ursp.expire) begin
              hold_armed[btn] <= 1'b0;
              if (held_flag[btn]) begin
                long_fired[btn] <= 1'b1;
              end
            end
          end
        end
        ST_REPEAT: begin
          if (emit) begin
            hold_armed[btn] <= 1'b1;
            hold_cd[btn]    <= repeat_ivl;
          end
        end
        ST_WINDOW: begin
          if (window_armed[btn]) begin
            window_cd[btn] <= ursp.countdown_next;
            if (ursp.expire) begin
              window_armed[btn] <= 1'b0;
              consec[btn]       <= '0;
            end
          end
        end
        ST_CHANGE: begin
          if (chg && !bounce) begin
            debounce_armed[btn] <= 1'b0;
            prior_level[btn]    <= pressed;
            if (do_press) begin
              held_flag[btn]    <= 1'b1;
              press_tally[btn]  <= press_tally[btn] + CNT_W'(1);
              long_fired[btn]   <= 1'b0;
              window_armed[btn] <= 1'b0;
              hold_armed[btn]   <= 1'b1;
              hold_cd[btn]      <= long_press_ms;
              if (ursp.le_multi) begin
                if (consec[btn] < CC_MAX) begin
                  consec[btn] <= consec[btn] + CC_W'(1);
                end
              end else begin
                consec[btn] <= CC_W'(1);
              end
            end else if (do_release) begin
              held_flag[btn]      <= 1'b0;
              release_stamp[btn]  <= now_count;
              debounce_armed[btn] <= 1'b1;
              hold_armed[btn]     <= 1'b0;
              if (!long_fired[btn]) begin
                window_armed[btn] <= 1'b1;
                window_cd[btn]    <= multi_press_ms;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.btn   = BTN_W'(btn);
    res.code  = emit_code;
    res.total = press_tally[btn];
  end

  bgd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (emit && go),
    .flush    (state == ST_DONE),
    .res      (res),
    .status   (ost),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // no result is held back once a request has closed
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ost.pend_valid)
    else $error("result still pending while idle");

  // an event is only produced when the output stage has room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (emit && go) |-> ost.room)
    else $error("event pushed without room");

  // button counter stays within the active buttons
  a_btn_range: assert property (@(posedge clk) disable iff (rst)
    btn <= LAST_BTN)
    else $error("button counter out of range");

  // a tick request advances the millisecond counter by one
  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser) |=> (now_count == $past(now_count) + CNT_W'(1)))
    else $error("tick did not advance the counter");

endmodule
